### sv/i2cms_pkg.sv
// ============================================================================
// i2cms_pkg
// Shared types and constants for the I2C master line sequencer.
// ============================================================================
package i2cms_pkg;

    typedef enum logic [1:0] {
        FN_START = 2'd0,
        FN_STOP  = 2'd1,
        FN_WRITE = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    localparam logic [15:0] PHASE_CYCLES_RST = 16'd20;

    localparam logic [4:0] PH_LAST_SHORT  = 5'd2;
    localparam logic [4:0] PH_BIT_END     = 5'd15;
    localparam logic [4:0] PH_LAST_WR_OK  = 5'd18;
    localparam logic [4:0] PH_LAST_WR_ERR = 5'd21;
    localparam logic [4:0] PH_LAST_RD_ACK = 5'd19;
    localparam logic [4:0] PH_LAST_RD_NAK = 5'd18;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] write_byte;
        logic       give_ack;
        logic [7:0] line_data;
        logic       line_ack;
    } t_in_word;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       last_phase;
        logic [7:0] read_value;
        logic       ack_error;
    } t_out_word;

    typedef struct packed {
        t_func      func;
        logic [7:0] data;
        logic       give_ack;
        logic       err;
        logic       first_scl;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

### sv/i2cms_front.sv
// ============================================================================
// i2cms_front
// Accepts command words, decodes them and tracks the bus clock level.
// ============================================================================
module i2cms_front import i2cms_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  t_in_word i_in_word,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_cmd     o_q_cmd
);

    logic  r_clk_lvl;
    logic  n_clk_lvl;
    t_func w_func;

    assign w_func   = t_func'(i_in_word.func);
    assign o_q_push = push && !i_q_full;

    always_comb begin
        o_q_cmd.func      = w_func;
        o_q_cmd.give_ack  = i_in_word.give_ack;
        o_q_cmd.err       = i_in_word.line_ack;
        o_q_cmd.first_scl = r_clk_lvl;
        o_q_cmd.data      = (w_func == FN_READ) ? i_in_word.line_data
                                                : i_in_word.write_byte;
        n_clk_lvl         = (w_func == FN_STOP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_lvl <= 1'b1;
        end else if (o_q_push) begin
            r_clk_lvl <= n_clk_lvl;
        end
    end

endmodule

### sv/i2cms_cmdq.sv
// ============================================================================
// i2cms_cmdq
// Two-entry command queue between the decode front and the phase back end.
// ============================================================================
module i2cms_cmdq import i2cms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_head o_head
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full       = (r_cnt == 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

### sv/i2cms_back.sv
// ============================================================================
// i2cms_back
// Steps through the line phases of the head command into a one-word output
// register, one per phase time while that register is empty or being popped.
// ============================================================================
module i2cms_back import i2cms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  t_q_head   i_head,
    output logic      o_q_pop,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_out_word
);

    logic [15:0] r_phase_cycles;
    logic [15:0] r_tmr;
    logic [4:0]  r_ph;
    logic        r_ovalid;
    t_out_word   r_out;
    t_out_word   w_word;
    logic [4:0]  w_last_ph;
    logic        w_bit;
    logic        w_go;
    t_cmd        w_cmd;

    assign w_cmd = i_head.cmd;
    assign w_bit = w_cmd.data[~r_ph[3:1]];

    always_comb begin
        w_word            = '0;
        w_last_ph         = PH_LAST_SHORT;
        unique case (w_cmd.func)
            FN_START: begin
                w_last_ph        = PH_LAST_SHORT;
                w_word.scl_level = (r_ph != 5'd2);
                w_word.sda_level = (r_ph == 5'd0);
            end
            FN_STOP: begin
                w_last_ph        = PH_LAST_SHORT;
                w_word.scl_level = (r_ph == 5'd0) ? w_cmd.first_scl : 1'b1;
                w_word.sda_level = (r_ph == 5'd2);
            end
            FN_WRITE: begin
                w_last_ph = w_cmd.err ? PH_LAST_WR_ERR : PH_LAST_WR_OK;
                priority if (r_ph <= PH_BIT_END) begin
                    w_word.scl_level = r_ph[0] ? 1'b1
                                     : ((r_ph == 5'd0) ? w_cmd.first_scl : 1'b0);
                    w_word.sda_level = w_bit;
                end else if (r_ph == 5'd16) begin
                    w_word.scl_level = 1'b0;
                    w_word.sda_level = 1'b1;
                end else if (r_ph == 5'd17) begin
                    w_word.scl_level = 1'b1;
                    w_word.sda_level = 1'b1;
                end else if (r_ph == w_last_ph) begin
                    w_word.scl_level = 1'b0;
                    w_word.sda_level = 1'b1;
                    w_word.ack_error = w_cmd.err;
                end else begin
                    w_word.scl_level = 1'b1;
                    w_word.sda_level = (r_ph == 5'd20);
                end
            end
            FN_READ: begin
                w_last_ph = w_cmd.give_ack ? PH_LAST_RD_ACK : PH_LAST_RD_NAK;
                priority if (r_ph <= PH_BIT_END) begin
                    w_word.scl_level = !r_ph[0];
                    w_word.sda_level = 1'b1;
                end else if (r_ph == w_last_ph) begin
                    w_word.scl_level  = 1'b0;
                    w_word.sda_level  = 1'b1;
                    w_word.read_value = w_cmd.data;
                end else begin
                    w_word.scl_level = (r_ph == 5'd17);
                    w_word.sda_level = !w_cmd.give_ack;
                end
            end
            default: begin
                w_word = '0;
            end
        endcase
        w_word.last_phase = (r_ph == w_last_ph);
    end

    assign w_go       = i_head.valid && (r_tmr == 16'd0) && (!r_ovalid || pop);
    assign o_q_pop    = w_go && w_word.last_phase;
    assign empty      = !r_ovalid;
    assign o_out_word = r_out;

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out <= w_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_cycles <= PHASE_CYCLES_RST;
            r_tmr          <= 16'd0;
            r_ph           <= 5'd0;
            r_ovalid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_phase_cycles <= i_cfg_data;
            end
            if (w_go) begin
                r_ovalid <= 1'b1;
                r_tmr    <= r_phase_cycles - 16'd1;
                r_ph     <= w_word.last_phase ? 5'd0 : r_ph + 5'd1;
            end else begin
                if (pop) begin
                    r_ovalid <= 1'b0;
                end
                if (r_tmr != 16'd0) begin
                    r_tmr <= r_tmr - 16'd1;
                end
            end
        end
    end

endmodule

### sv/i2c_master_line_sequencer_core.sv
// ============================================================================
// i2c_master_line_sequencer_core
// I2C master line sequencer: expands start, stop, write and read commands
// into a run of SCL/SDA line-state words.
// ============================================================================
// Each command word expands into 3 to 22 line-state words (start and stop 3,
// write 19 or 22, read 19 or 20). The back end emits one line-state word per
// phase time, set by its phase timer, while its output register is empty or
// being popped. Commands enter a two-deep queue and are accepted in consecutive
// cycles while it has room.
module i2c_master_line_sequencer_core import i2cms_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  t_in_word    i_in_word,
    output logic        empty,
    input  logic        pop,
    output t_out_word   o_out_word
);

    logic    w_q_push;
    logic    w_q_pop;
    t_cmd    w_q_cmd;
    t_q_head w_head;

    i2cms_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .i_in_word (i_in_word),
        .i_q_full  (full),
        .o_q_push  (w_q_push),
        .o_q_cmd   (w_q_cmd)
    );

    i2cms_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_q_cmd),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_head  (w_head)
    );

    i2cms_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_head     (w_head),
        .o_q_pop    (w_q_pop),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

`ifndef ASSERT_OFF
    a_err_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_word.ack_error) |-> o_out_word.last_phase)
        else $error("ack_error outside last phase");

    a_rd_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_out_word.read_value != 8'd0)) |-> o_out_word.last_phase)
        else $error("read_value outside last phase");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not clear after reset");
`endif

endmodule

### tb/i2c_master_line_sequencer_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// i2c_master_line_sequencer_core_tb
// Self-checking bench for the I2C master line sequencer. Commands go in through
// the push/full side. A bus-level model expands each accepted command into its
// SCL/SDA line words, and every popped word is compared field by field. A
// directed table comes first, then random transactions, with random gaps on
// both sides. The phase-time register is written with 1, 65535 and 2 to 6.
// ============================================================================
module i2c_master_line_sequencer_core_tb;
    import i2cms_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int LONG_HOLD   = 500;
    localparam int TAIL_CYCLES = 200;

    typedef struct packed {
        t_in_word  cmd;
        logic      typed;
        t_out_word last;
    } t_dir_row;

    logic        i_clk      = 1'b1;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        push       = 1'b0;
    logic        full;
    t_in_word    i_in_word  = '0;
    logic        empty;
    logic        pop        = 1'b0;
    t_out_word   o_out_word;

    t_out_word line_q[$];
    logic      bus_scl  = 1'b1;
    int        errors   = 0;
    int        rx_gap   = 0;
    int        rx_hold  = 0;
    bit        no_idle  = 1'b0;
    logic      hold_rx  = 1'b0;
    int        cyc      = 0;
    t_dir_row  dir_tab[22];

    i2c_master_line_sequencer_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("i2c_master_line_sequencer_core_tb: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic void put_line(logic scl, logic sda);
        t_out_word w;
        w = '0;
        w.scl_level = scl;
        w.sda_level = sda;
        line_q.push_back(w);
    endfunction

    function automatic void put_stop();
        put_line(bus_scl, 1'b0);
        put_line(1'b1, 1'b0);
        put_line(1'b1, 1'b1);
        bus_scl = 1'b1;
    endfunction

    // expand one command into the line words it drives on the bus
    function automatic void expand_cmd(t_in_word c);
        logic sclv;
        sclv = bus_scl;
        case (c.func)
            FN_START: begin
                put_line(1'b1, 1'b1);
                put_line(1'b1, 1'b0);
                put_line(1'b0, 1'b0);
                bus_scl = 1'b0;
            end
            FN_STOP: begin
                put_stop();
            end
            FN_WRITE: begin
                for (int i = 7; i >= 0; i--) begin
                    put_line(sclv, c.write_byte[i]);
                    put_line(1'b1, c.write_byte[i]);
                    sclv = 1'b0;
                end
                put_line(1'b0, 1'b1);
                put_line(1'b1, 1'b1);
                bus_scl = 1'b1;
                if (c.line_ack)
                    put_stop();
                put_line(1'b0, 1'b1);
                bus_scl = 1'b0;
                line_q[$].ack_error = c.line_ack;
            end
            default: begin
                for (int i = 0; i < 8; i++) begin
                    put_line(1'b1, 1'b1);
                    put_line(1'b0, 1'b1);
                end
                if (c.give_ack) begin
                    put_line(1'b0, 1'b0);
                    put_line(1'b1, 1'b0);
                    put_line(1'b0, 1'b0);
                    put_line(1'b0, 1'b1);
                end else begin
                    put_line(1'b0, 1'b1);
                    put_line(1'b1, 1'b1);
                    put_line(1'b0, 1'b1);
                end
                bus_scl = 1'b0;
                line_q[$].read_value = c.line_data;
            end
        endcase
        line_q[$].last_phase = 1'b1;
    endfunction

    function automatic void cmp_field(string nm, logic [7:0] e, logic [7:0] a);
        if (a !== e) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, nm, e, a);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word ew;
        if (i_rst_n && pop && !empty) begin
            if (line_q.size() == 0) begin
                $display("%0t: unexpected line word: expected none, got %h",
                         $time, o_out_word);
                errors++;
            end else begin
                ew = line_q.pop_front();
                cmp_field("scl_level", 8'(ew.scl_level), 8'(o_out_word.scl_level));
                cmp_field("sda_level", 8'(ew.sda_level), 8'(o_out_word.sda_level));
                cmp_field("last_phase", 8'(ew.last_phase), 8'(o_out_word.last_phase));
                cmp_field("read_value", ew.read_value, o_out_word.read_value);
                cmp_field("ack_error", 8'(ew.ack_error), 8'(o_out_word.ack_error));
            end
            rx_gap = pick_gap();
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_rx) begin
            hold_rx <= 1'b0;
            rx_hold = LONG_HOLD;
            pop <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            pop <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    function automatic t_in_word mk(t_func f, logic [7:0] wb, logic ga, logic [7:0] ld,
                                    logic la);
        t_in_word c;
        c.func       = f;
        c.write_byte = wb;
        c.give_ack   = ga;
        c.line_data  = ld;
        c.line_ack   = la;
        return c;
    endfunction

    function automatic t_out_word fin(logic scl, logic sda, logic [7:0] rv, logic ae);
        t_out_word w;
        w.scl_level  = scl;
        w.sda_level  = sda;
        w.last_phase = 1'b1;
        w.read_value = rv;
        w.ack_error  = ae;
        return w;
    endfunction

    function automatic t_dir_row row(t_in_word c, logic typed, t_out_word last);
        t_dir_row r;
        r.cmd   = c;
        r.typed = typed;
        r.last  = last;
        return r;
    endfunction

    function automatic t_in_word rand_word(t_func f);
        t_in_word c;
        c          = t_in_word'($urandom);
        c.func     = f;
        c.line_ack = ($urandom_range(0, 3) == 0);
        return c;
    endfunction

    // offer one word, hold until taken, then queue its line words
    task automatic issue(t_in_word c, logic typed, t_out_word last);
        int gap;
        push      <= 1'b1;
        i_in_word <= c;
        do @(posedge i_clk); while (full);
        expand_cmd(c);
        if (typed)
            line_q[$] = last;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            push      <= 1'b0;
            i_in_word <= t_in_word'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send(t_func f);
        issue(rand_word(f), 1'b0, '0);
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(negedge i_clk); while (line_q.size() != 0);
    endtask

    task automatic set_phase_cycles(logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= 16'($urandom);
    endtask

    // mostly framed transactions, the rest loose commands
    task automatic run_random(int n);
        int left, ops;
        left = n;
        while (left > 0) begin
            if ($urandom_range(0, 99) < 80) begin
                ops = $urandom_range(0, 4);
                send(FN_START);
                send(FN_WRITE);
                repeat (ops)
                    send($urandom_range(0, 1) ? FN_WRITE : FN_READ);
                send(FN_STOP);
                left -= ops + 3;
            end else begin
                send(t_func'($urandom_range(0, 3)));
                left--;
            end
        end
    endtask

    initial begin
        dir_tab = '{
            row(mk(FN_START, 8'h00, 1'b0, 8'h00, 1'b0), 1'b1, fin(1'b0, 1'b0, 8'h00, 1'b0)),
            row(mk(FN_WRITE, 8'hFF, 1'b1, 8'hFF, 1'b0), 1'b1, fin(1'b0, 1'b1, 8'h00, 1'b0)),
            row(mk(FN_WRITE, 8'h00, 1'b0, 8'h00, 1'b1), 1'b1, fin(1'b0, 1'b1, 8'h00, 1'b1)),
            row(mk(FN_STOP,  8'h00, 1'b0, 8'h00, 1'b0), 1'b1, fin(1'b1, 1'b1, 8'h00, 1'b0)),
            row(mk(FN_WRITE, 8'hA5, 1'b0, 8'h00, 1'b0), 1'b0, '0),
            row(mk(FN_WRITE, 8'h5A, 1'b1, 8'hFF, 1'b1), 1'b0, '0),
            row(mk(FN_START, 8'hFF, 1'b1, 8'hFF, 1'b1), 1'b0, '0),
            row(mk(FN_READ,  8'h00, 1'b1, 8'hFF, 1'b0), 1'b1, fin(1'b0, 1'b1, 8'hFF, 1'b0)),
            row(mk(FN_READ,  8'hFF, 1'b0, 8'h00, 1'b1), 1'b1, fin(1'b0, 1'b1, 8'h00, 1'b0)),
            row(mk(FN_READ,  8'h12, 1'b1, 8'h3C, 1'b0), 1'b0, '0),
            row(mk(FN_STOP,  8'hFF, 1'b1, 8'hFF, 1'b1), 1'b0, '0),
            row(mk(FN_STOP,  8'h00, 1'b0, 8'h00, 1'b0), 1'b1, fin(1'b1, 1'b1, 8'h00, 1'b0)),
            row(mk(FN_START, 8'h00, 1'b0, 8'h00, 1'b0), 1'b0, '0),
            row(mk(FN_START, 8'h00, 1'b0, 8'h00, 1'b0), 1'b0, '0),
            row(mk(FN_READ,  8'hFF, 1'b0, 8'h81, 1'b1), 1'b0, '0),
            row(mk(FN_WRITE, 8'h80, 1'b1, 8'hFF, 1'b0), 1'b0, '0),
            row(mk(FN_WRITE, 8'h01, 1'b1, 8'hFF, 1'b1), 1'b0, '0),
            row(mk(FN_READ,  8'h00, 1'b1, 8'h7E, 1'b0), 1'b0, '0),
            row(mk(FN_STOP,  8'h00, 1'b0, 8'h00, 1'b0), 1'b0, '0),
            row(mk(FN_READ,  8'h00, 1'b0, 8'hC3, 1'b0), 1'b0, '0),
            row(mk(FN_WRITE, 8'h7F, 1'b0, 8'h00, 1'b0), 1'b0, '0),
            row(mk(FN_STOP,  8'h00, 1'b0, 8'h00, 1'b0), 1'b0, '0)
        };

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[k])
            issue(dir_tab[k].cmd, dir_tab[k].typed, dir_tab[k].last);
        drain();

        // fastest phase; stall the receiver while the sender keeps pushing
        set_phase_cycles(16'd1);
        no_idle = 1'b1;
        hold_rx <= 1'b1;
        run_random(20);
        no_idle = 1'b0;
        run_random(50);
        drain();
        run_random(60);
        drain();

        // slowest phase, one short command only
        set_phase_cycles(16'hFFFF);
        send(FN_START);
        drain();

        set_phase_cycles(16'($urandom_range(2, 6)));
        no_idle = 1'b1;
        run_random(40);
        no_idle = 1'b0;
        run_random(90);
        drain();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("i2c_master_line_sequencer_core_tb: PASS");
        else
            $display("i2c_master_line_sequencer_core_tb: FAIL");
        $finish;
    end

endmodule

### sim.f
sv/i2cms_pkg.sv
sv/i2cms_front.sv
sv/i2cms_cmdq.sv
sv/i2cms_back.sv
sv/i2c_master_line_sequencer_core.sv
tb/i2c_master_line_sequencer_core_tb.sv
